>>> hw/rtl/ssa_pkg.sv
`timescale 1ns / 1ps
package ssa_pkg;

	// Configuration register widths and word indexes
	localparam int THRESH_W = 31;
	localparam int LEN_W    = 17;
	localparam int STATUS_W = 3;

	localparam logic REG_THRESH = 1'b0;
	localparam logic REG_LEN    = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ACCUM    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CANCEL   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	// Row operations broadcast to every cell
	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;
	localparam logic [1:0] OP_ACCUM  = 2'd3;

	typedef struct packed {
		logic       capture;
		logic [1:0] op;
	} ssa_ctrl_t;

endpackage

>>> hw/rtl/ssa_cell.sv
`timescale 1ns / 1ps
module ssa_cell import ssa_pkg::*; #(
	parameter int INDEX_BITS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssa_ctrl_t             ctrl,
	input  logic [INDEX_BITS-1:0] key,
	input  logic [VALUE_BITS-1:0] addend,
	input  logic                  occupied,
	input  logic                  left_ge,
	input  logic [INDEX_BITS-1:0] left_index,
	input  logic [VALUE_BITS-1:0] left_value,
	input  logic [INDEX_BITS-1:0] right_index,
	input  logic [VALUE_BITS-1:0] right_value,
	output logic [INDEX_BITS-1:0] index_q,
	output logic [VALUE_BITS-1:0] value_q,
	output logic                  ge,
	output logic                  pos,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] sum
);

	logic                  ge_q;
	logic                  eq_q;
	logic [VALUE_BITS-1:0] sum_q;
	logic [VALUE_BITS:0]   raw_sum;
	logic [VALUE_BITS-1:0] sat_sum;

	// Saturating add of the broadcast value onto the held value
	always_comb begin
		raw_sum = {value_q[VALUE_BITS-1], value_q} + {addend[VALUE_BITS-1], addend};
		if (raw_sum[VALUE_BITS] != raw_sum[VALUE_BITS-1]) begin
			sat_sum = {raw_sum[VALUE_BITS], {(VALUE_BITS-1){~raw_sum[VALUE_BITS]}}};
		end else begin
			sat_sum = raw_sum[VALUE_BITS-1:0];
		end
	end

	// Capture compare flags against the broadcast key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctrl.capture) begin
			ge_q <= !(occupied && (index_q < key));
			eq_q <= occupied && (index_q == key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			sum_q <= sat_sum;
		end
	end

	// Insert shifts up from the left, cancel shifts down from the right, accumulate writes the sum into the hit cell
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (ge_q && !left_ge) begin
					index_q <= key;
					value_q <= addend;
				end else if (ge_q) begin
					index_q <= left_index;
					value_q <= left_value;
				end
			end
			OP_CANCEL: begin
				if (ge_q) begin
					index_q <= right_index;
					value_q <= right_value;
				end
			end
			OP_ACCUM: begin
				if (eq_q) begin
					value_q <= sum_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign ge  = ge_q;
	assign pos = ge_q && !left_ge;
	assign hit = eq_q;
	assign sum = sum_q;

endmodule

>>> hw/rtl/sorted_sparse_accumulator.sv
`timescale 1ns / 1ps
// Sorted sparse vector accumulator. Raise start with an index and a signed
// value while busy is low; the item is taken at that edge and busy stays high
// until it is through, so one item is handled at a time. The entries sit in a
// row of CAPACITY cells kept sorted by index: a compare step checks every cell
// against the index and forms its sum, a select step picks the matching cell,
// and an update step shifts the row or updates the hit cell. The result is
// shown for exactly one cycle with done high, in the same cycle busy falls; it
// cannot be held off, so the receiver must take it then. Configuration must be
// written over the APB port only while busy is low, which the block does not
// enforce; paddr[2] selects the register (0 zero threshold, 1 initial length).
module sorted_sparse_accumulator import ssa_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int INDEX_BITS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [INDEX_BITS-1:0]           entry_index,
	input  logic signed [VALUE_BITS-1:0]    entry_value,
	output logic                            done,
	output logic [STATUS_W-1:0]             status,
	output logic [$clog2(CAPACITY)-1:0]     slot,
	output logic signed [VALUE_BITS-1:0]    stored_value,
	output logic [$clog2(CAPACITY+1)-1:0]   entry_count,
	output logic [LEN_W-1:0]                vector_length,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int TW = INDEX_BITS + 1;
	localparam int LW = (TW > LEN_W) ? TW : LEN_W;
	localparam int ZW = (VALUE_BITS > THRESH_W) ? VALUE_BITS : THRESH_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_SEL  = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	logic [1:0]            state_q;
	logic [THRESH_W-1:0]   thresh_q;
	logic [LEN_W-1:0]      init_len_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         count_q;
	logic [TW-1:0]         top_q;
	logic                  ignore_q;
	logic                  found_q;
	logic [VALUE_BITS-1:0] selval_q;
	logic [SW-1:0]         slot_q;

	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;
	logic [SW-1:0]         oslot_q;
	logic [VALUE_BITS-1:0] ovalue_q;
	logic [LEN_W-1:0]      olen_q;

	ssa_ctrl_t             ctrl;
	logic                  accept;
	logic                  cfg_wr;

	logic [INDEX_BITS-1:0] cell_index [CAPACITY];
	logic [VALUE_BITS-1:0] cell_value [CAPACITY];
	logic [VALUE_BITS-1:0] cell_sum   [CAPACITY];
	logic [CAPACITY-1:0]   cell_ge;
	logic [CAPACITY-1:0]   cell_pos;
	logic [CAPACITY-1:0]   cell_hit;

	logic                  found;
	logic [VALUE_BITS-1:0] selval;
	logic [SW-1:0]         pos_slot;

	logic                  sum_zero;
	logic [1:0]            op;
	logic [STATUS_W-1:0]   status_d;
	logic [SW-1:0]         slot_d;
	logic [VALUE_BITS-1:0] value_d;
	logic [CW-1:0]         count_d;
	logic [TW-1:0]         top_d;
	logic [TW-1:0]         idx_plus;
	logic [LW-1:0]         len_wide;

	// Magnitude at or below the threshold counts as zero
	function automatic logic is_zero(input logic [VALUE_BITS-1:0] v,
	                                 input logic [THRESH_W-1:0] th);
		logic [VALUE_BITS-1:0] mag;
		begin
			mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
			is_zero = ZW'(mag) <= ZW'(th);
		end
	endfunction

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= '0;
			init_len_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_THRESH: thresh_q   <= pwdata[THRESH_W-1:0];
				REG_LEN:    init_len_q <= pwdata[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LEN) ? 32'(init_len_q) : 32'(thresh_q);

	// Sequence one item through compare, select and update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (accept) state_q <= S_CMP;
				S_CMP:   state_q <= S_SEL;
				S_SEL:   state_q <= S_UPD;
				S_UPD:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the item, its zero flag and the selected match
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= entry_index;
			val_q <= entry_value;
		end
		if (state_q == S_CMP) begin
			ignore_q <= is_zero(val_q, thresh_q);
		end
		if (state_q == S_SEL) begin
			found_q  <= found;
			selval_q <= selval;
			slot_q   <= pos_slot;
		end
	end

	assign ctrl.capture = (state_q == S_CMP);
	assign ctrl.op      = (state_q == S_UPD) ? op : OP_NONE;

	// Row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  occ;
		logic                  lge;
		logic [INDEX_BITS-1:0] lidx;
		logic [VALUE_BITS-1:0] lval;
		logic [INDEX_BITS-1:0] ridx;
		logic [VALUE_BITS-1:0] rval;

		assign occ = CW'(i) < count_q;

		if (i == 0) begin : g_first
			assign lge  = 1'b0;
			assign lidx = '0;
			assign lval = '0;
		end else begin : g_mid
			assign lge  = cell_ge[i-1];
			assign lidx = cell_index[i-1];
			assign lval = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign ridx = '0;
			assign rval = '0;
		end else begin : g_inner
			assign ridx = cell_index[i+1];
			assign rval = cell_value[i+1];
		end

		ssa_cell #(
			.INDEX_BITS(INDEX_BITS),
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key        (idx_q),
			.addend     (val_q),
			.occupied   (occ),
			.left_ge    (lge),
			.left_index (lidx),
			.left_value (lval),
			.right_index(ridx),
			.right_value(rval),
			.index_q    (cell_index[i]),
			.value_q    (cell_value[i]),
			.ge         (cell_ge[i]),
			.pos        (cell_pos[i]),
			.hit        (cell_hit[i]),
			.sum        (cell_sum[i])
		);
	end

	// Select the hit sum and encode the sorted position
	always_comb begin
		selval   = '0;
		pos_slot = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			selval   = selval | ({VALUE_BITS{cell_hit[i]}} & cell_sum[i]);
			pos_slot = pos_slot | ({SW{cell_pos[i]}} & SW'(i));
		end
	end

	assign found = |cell_hit;

	// Decide the row operation and the result
	always_comb begin
		sum_zero = is_zero(selval_q, thresh_q);
		idx_plus = TW'(idx_q) + 1'b1;
		op       = OP_NONE;
		status_d = ST_IGNORED;
		slot_d   = '0;
		value_d  = '0;
		count_d  = count_q;
		top_d    = top_q;
		if (!ignore_q) begin
			if (idx_plus > top_q) begin
				top_d = idx_plus;
			end
			if (found_q && sum_zero) begin
				op       = OP_CANCEL;
				status_d = ST_CANCEL;
				slot_d   = slot_q;
				count_d  = count_q - 1'b1;
			end else if (found_q) begin
				op       = OP_ACCUM;
				status_d = ST_ACCUM;
				slot_d   = slot_q;
				value_d  = selval_q;
			end else if (count_q == CW'(CAPACITY)) begin
				status_d = ST_FULL;
			end else begin
				op       = OP_INSERT;
				status_d = ST_INSERTED;
				slot_d   = slot_q;
				value_d  = val_q;
				count_d  = count_q + 1'b1;
			end
		end
		len_wide = (LW'(init_len_q) > LW'(top_d)) ? LW'(init_len_q) : LW'(top_d);
	end

	// Advance entry count and top index, and register done from the update state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			top_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_UPD);
			if (state_q == S_UPD) begin
				count_q <= count_d;
				top_q   <= top_d;
			end
		end
	end

	// Register the result
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			status_q <= status_d;
			oslot_q  <= slot_d;
			ovalue_q <= value_d;
			olen_q   <= len_wide[LEN_W-1:0];
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign slot          = oslot_q;
	assign stored_value  = ovalue_q;
	assign entry_count   = count_q;
	assign vector_length = olen_q;

endmodule

>>> dv/sorted_sparse_accumulator_tb.sv
`timescale 1ns / 1ps
module sorted_sparse_accumulator_tb;
	import ssa_pkg::*;

	localparam int     CAP         = 64;
	localparam longint VAL_MAX     = 64'sd2147483647;
	localparam longint VAL_MIN     = -64'sd2147483648;
	localparam int     CYCLE_LIMIT = 100000;

	typedef struct {
		logic [15:0] index;
		logic [31:0] value;
	} entry_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [5:0]          slot;
		logic [31:0]         stored_value;
		logic [6:0]          entry_count;
		logic [LEN_W-1:0]    vector_length;
	} outcome_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic [15:0] entry_index = '0;
	logic [31:0] entry_value = '0;
	logic        psel        = 1'b0;
	logic        penable     = 1'b0;
	logic        pwrite      = 1'b0;
	logic [2:0]  paddr       = '0;
	logic [31:0] pwdata      = '0;

	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [5:0]          slot;
	logic [31:0]         stored_value;
	logic [6:0]          entry_count;
	logic [LEN_W-1:0]    vector_length;
	logic [31:0]         prdata;
	logic                pready;

	// Predicted contents of the sorted store and the registers
	logic [15:0]         held_index [CAP];
	logic [31:0]         held_value [CAP];
	int                  held_count   = 0;
	logic [LEN_W-1:0]    top_plus_one = '0;
	logic [THRESH_W-1:0] thresh_reg   = '0;
	logic [LEN_W-1:0]    length_reg   = '0;

	entry_t   entry_queue[$];
	outcome_t outcome_queue[$];
	outcome_t want;
	int       errors    = 0;
	int       cycles    = 0;
	int       idle_left = 0;
	bit       idle_on   = 1'b1;
	bit       took_item = 1'b0;

	sorted_sparse_accumulator DUT (.*);

	always #1 clk = ~clk;

	function automatic bit is_negligible(longint v);
		longint mag;
		mag = (v < 0) ? -v : v;
		return mag <= longint'(thresh_reg);
	endfunction

	// Apply one item to the predicted store and return the result it yields
	function automatic outcome_t accumulate_entry(logic [15:0] idx, logic [31:0] raw);
		outcome_t r;
		longint   val;
		longint   sum;
		int       pos;
		val = longint'(signed'(raw));
		r.status = ST_IGNORED;
		r.slot = '0;
		r.stored_value = '0;
		pos = 0;
		if (!is_negligible(val)) begin
			if ({1'b0, idx} + 17'd1 > top_plus_one)
				top_plus_one = {1'b0, idx} + 17'd1;
			while (pos < held_count && held_index[pos] < idx)
				pos++;
			if (pos < held_count && held_index[pos] == idx) begin
				sum = longint'(signed'(held_value[pos])) + val;
				if (sum > VAL_MAX)
					sum = VAL_MAX;
				else if (sum < VAL_MIN)
					sum = VAL_MIN;
				r.slot = pos[5:0];
				if (is_negligible(sum)) begin
					// drop the entry and close the gap
					for (int i = pos; i < held_count - 1; i++) begin
						held_index[i] = held_index[i + 1];
						held_value[i] = held_value[i + 1];
					end
					held_count--;
					r.status = ST_CANCEL;
				end else begin
					held_value[pos] = sum[31:0];
					r.stored_value = sum[31:0];
					r.status = ST_ACCUM;
				end
			end else if (held_count >= CAP) begin
				r.status = ST_FULL;
			end else begin
				// open a gap at the sorted position and insert
				for (int i = held_count; i > pos; i--) begin
					held_index[i] = held_index[i - 1];
					held_value[i] = held_value[i - 1];
				end
				held_index[pos] = idx;
				held_value[pos] = raw;
				held_count++;
				r.slot = pos[5:0];
				r.stored_value = raw;
				r.status = ST_INSERTED;
			end
		end
		r.entry_count = 7'(held_count);
		r.vector_length = (length_reg > top_plus_one) ? length_reg : top_plus_one;
		return r;
	endfunction

	function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, what, exp_v, got_v);
		end
	endfunction

	// Take items at the edge and check results against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				if (done === 1'b1) begin
					if (outcome_queue.size() == 0) begin
						errors++;
						$display("%0t: result with no item outstanding, status %0d",
							$time, status);
					end else begin
						want = outcome_queue.pop_front();
						check_field("status", 32'(want.status), 32'(status));
						check_field("slot", 32'(want.slot), 32'(slot));
						check_field("stored_value", want.stored_value, stored_value);
						check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
						check_field("vector_length", 32'(want.vector_length),
							32'(vector_length));
					end
				end
				if (start && !busy) begin
					outcome_queue.push_back(accumulate_entry(entry_index, entry_value));
					void'(entry_queue.pop_front());
					took_item = 1'b1;
				end
			end
		end
	end

	// Present the next item, hold it until taken, insert random idle bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || took_item) begin
				if (idle_left != 0) begin
					idle_left <= idle_left - 1;
					start <= 1'b0;
				end else if (idle_on && entry_queue.size() != 0 &&
						$urandom_range(0, 5) == 0) begin
					idle_left <= $urandom_range(0, 4);
					start <= 1'b0;
				end else if (entry_queue.size() != 0) begin
					start <= 1'b1;
					entry_index <= entry_queue[0].index;
					entry_value <= entry_queue[0].value;
				end else begin
					start <= 1'b0;
				end
			end
			took_item = 1'b0;
		end
	end

	function automatic void push_entry(logic [15:0] idx, logic [31:0] v);
		entry_queue.push_back('{index: idx, value: v});
	endfunction

	function automatic logic [31:0] rand_value(logic [THRESH_W-1:0] th);
		longint t;
		longint v;
		t = longint'(th);
		case ($urandom_range(0, 7))
			0: v = longint'(signed'(32'($urandom)));
			1: begin
				case ($urandom_range(0, 6))
					0: v = VAL_MAX;
					1: v = VAL_MIN;
					2: v = t;
					3: v = -t;
					4: v = t + 1;
					5: v = -t - 1;
					default: v = 0;
				endcase
			end
			2, 3, 4: v = t + longint'($urandom_range(1, 4096));
			5, 6: v = -t - longint'($urandom_range(1, 4096));
			default: begin
				v = longint'($urandom_range(0, th));
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v[31:0];
	endfunction

	function automatic logic [15:0] pick_index(logic [15:0] base, int step, int pool);
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1, 2: return 16'($urandom);
			default: return base + 16'(step * $urandom_range(0, pool - 1));
		endcase
	endfunction

	// Queue random items over a pool of indexes, with matched cancelling pairs
	task automatic queue_mix(int n, logic [15:0] base, int step, int pool,
			logic [THRESH_W-1:0] th);
		logic [15:0] idx;
		longint      v;
		longint      d;
		for (int k = 0; k < n; k++) begin
			idx = pick_index(base, step, pool);
			if ($urandom_range(0, 4) == 0) begin
				v = longint'($urandom_range(32'(th) + 1, 32'h7FFF_FFFF));
				if ($urandom_range(0, 1))
					v = -v;
				d = longint'($urandom_range(0, 2 * 32'(th))) - longint'(th);
				push_entry(idx, v[31:0]);
				push_entry(idx, 32'(d - v));
				k++;
			end else begin
				push_entry(idx, rand_value(th));
			end
		end
	endtask

	// Write a register over APB, then read it back
	task automatic write_register(logic which, logic [31:0] data);
		logic [31:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (which == REG_THRESH) begin
			thresh_reg = data[THRESH_W-1:0];
			readback = 32'(data[THRESH_W-1:0]);
		end else begin
			length_reg = data[LEN_W-1:0];
			readback = 32'(data[LEN_W-1:0]);
		end
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== readback) begin
			errors++;
			$display("%0t: register %0d readback expected %h actual %h",
				$time, which, readback, prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_idle();
		while (entry_queue.size() != 0 || outcome_queue.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	initial begin
		logic [THRESH_W-1:0] th;
		logic [15:0]         base;
		int                  step;
		longint              v;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Extremes, saturation both ways, cancel and insert in the middle
		push_entry(16'd5, 32'h0000_0000);
		push_entry(16'd5, 32'h0001_0000);
		push_entry(16'hFFFF, 32'h7FFF_FFFF);
		push_entry(16'hFFFF, 32'h0000_0001);
		push_entry(16'd0, 32'h8000_0000);
		push_entry(16'd0, 32'h8000_0000);
		push_entry(16'd0, 32'h7FFF_FFFF);
		push_entry(16'd0, 32'h0000_0001);
		push_entry(16'd300, 32'h0000_0003);
		push_entry(16'd300, 32'hFFFF_FFFD);
		push_entry(16'd5, 32'hFFFF_0000);
		push_entry(16'hFFFF, 32'h8000_0000);
		push_entry(16'hFFFF, 32'h0000_0001);
		push_entry(16'd1, 32'hFFFF_FFFF);
		push_entry(16'd2, 32'h5555_5555);
		push_entry(16'd3, 32'hAAAA_AAAA);
		wait_idle();

		// Threshold edges: equal magnitude is ignored, sum landing on it cancels
		write_register(REG_THRESH, 32'h0000_0100);
		write_register(REG_LEN, 32'd65536);
		push_entry(16'd9, 32'h0000_0100);
		push_entry(16'd9, 32'hFFFF_FF00);
		push_entry(16'd9, 32'h0000_0101);
		push_entry(16'd9, 32'hFFFF_FFFF);
		push_entry(16'd9, 32'h8000_0000);
		push_entry(16'd2, 32'hAAAA_AAAB);
		wait_idle();

		// Dense traffic over a small pool with defaults restored
		write_register(REG_THRESH, 32'd0);
		write_register(REG_LEN, 32'd0);
		queue_mix(350, 16'd0, 1, 24, '0);
		wait_idle();

		// Fill the store past capacity, then churn it
		th = 31'd16;
		write_register(REG_THRESH, 32'(th));
		write_register(REG_LEN, 32'd1000);
		base = 16'($urandom);
		step = $urandom_range(1, 600);
		for (int k = 0; k < 130; k++) begin
			v = longint'(th) + longint'($urandom_range(1, 1 << 20));
			if ($urandom_range(0, 1))
				v = -v;
			push_entry(base + 16'(step * $urandom_range(0, 95)), v[31:0]);
		end
		queue_mix(170, base, step, 96, th);
		wait_idle();

		// Largest threshold: only the most negative value gets through
		th = 31'h7FFF_FFFF;
		write_register(REG_THRESH, 32'(th));
		write_register(REG_LEN, 32'd65536);
		for (int k = 0; k < 40; k++)
			push_entry(pick_index(16'd0, 1, 8),
				($urandom_range(0, 2) == 0) ? 32'h8000_0000 : rand_value(th));
		wait_idle();

		// Random settings
		th = 31'($urandom_range(0, 4096));
		write_register(REG_THRESH, 32'(th));
		write_register(REG_LEN, 32'($urandom_range(0, 65536)));
		queue_mix(300, 16'($urandom), $urandom_range(1, 3), 40, th);
		wait_idle();

		th = 31'($urandom_range(0, 4096));
		write_register(REG_THRESH, 32'(th));
		write_register(REG_LEN, 32'($urandom_range(0, 65536)));
		base = 16'($urandom);
		queue_mix(130, base, 1, 40, th);
		while (entry_queue.size() != 0)
			@(posedge clk);
		// finish at full rate with no idling
		idle_on = 1'b0;
		queue_mix(200, base, 1, 40, th);
		wait_idle();

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
